/* rtl/core/morse_text_codec_assert.svh */
// shared assertion macros, clocked on clock and disabled during reset
`ifndef MORSE_TEXT_CODEC_ASSERT_SVH
`define MORSE_TEXT_CODEC_ASSERT_SVH

// condition holds on every edge
`define MTC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle
`define MTC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define MTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/mtc_pkg.sv */
package mtc_pkg;

   localparam int MAX_SYMBOLS_DEF = 6;
   localparam int TABLE_SIZE      = 44;
   localparam int CODE_W          = 6;
   localparam int CODE_LEN_W      = 3;
   localparam int STEP_W          = 3;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   typedef struct packed {
      logic [7:0] char_in;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } rsp_type;

   // first symbol in bit 0, dash = 1
   typedef struct packed {
      logic [CODE_LEN_W-1:0] len;
      logic [CODE_W-1:0]     bits;
   } code_type;

   typedef struct packed {
      logic     hit;
      code_type code;
   } enc_type;

   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic has_results;
      logic step_last;
      logic out_free;
   } stat_type;

   localparam logic [7:0] TABLE_CHARS [TABLE_SIZE] = '{
      "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "l", "m",
      "n", "o", "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z",
      "1", "2", "3", "4", "5", "6", "7", "8", "9", "0",
      ".", "?", ",", "+", "-", "=", ";", ":"
   };

   localparam code_type TABLE_CODES [TABLE_SIZE] = '{
      '{3'd2, 6'b000010}, '{3'd4, 6'b000001}, '{3'd4, 6'b000101},
      '{3'd3, 6'b000001}, '{3'd1, 6'b000000}, '{3'd4, 6'b000100},
      '{3'd3, 6'b000011}, '{3'd4, 6'b000000}, '{3'd2, 6'b000000},
      '{3'd4, 6'b001110}, '{3'd3, 6'b000101}, '{3'd4, 6'b000010},
      '{3'd2, 6'b000011}, '{3'd2, 6'b000001}, '{3'd3, 6'b000111},
      '{3'd4, 6'b000110}, '{3'd4, 6'b001011}, '{3'd3, 6'b000010},
      '{3'd3, 6'b000000}, '{3'd1, 6'b000001}, '{3'd3, 6'b000100},
      '{3'd4, 6'b001000}, '{3'd3, 6'b000110}, '{3'd4, 6'b001001},
      '{3'd4, 6'b001101}, '{3'd4, 6'b000011},
      '{3'd5, 6'b011110}, '{3'd5, 6'b011100}, '{3'd5, 6'b011000},
      '{3'd5, 6'b010000}, '{3'd5, 6'b000000}, '{3'd5, 6'b000001},
      '{3'd5, 6'b000011}, '{3'd5, 6'b000111}, '{3'd5, 6'b001111},
      '{3'd5, 6'b011111},
      '{3'd6, 6'b101010}, '{3'd6, 6'b001100}, '{3'd6, 6'b110011},
      '{3'd5, 6'b001010}, '{3'd6, 6'b100001}, '{3'd5, 6'b010001},
      '{3'd6, 6'b010101}, '{3'd6, 6'b000111}
   };

   function automatic enc_type enc_find(input logic [7:0] c);
      logic [7:0] lc;
      enc_type    res;
      lc  = c;
      res = '0;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         lc = c | CASE_BIT;
      end
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (TABLE_CHARS[i] == lc) begin
            res.hit  = 1'b1;
            res.code = TABLE_CODES[i];
         end
      end
      return res;
   endfunction

endpackage

/* rtl/core/mtc_ctrl.sv */
module mtc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mtc_pkg::stat_type stat,
   output mtc_pkg::cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid && stat.has_results) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = stat.out_free;
            if (stat.out_free && stat.step_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

/* rtl/core/mtc_dpath.sv */
`include "morse_text_codec_assert.svh"

module mtc_dpath #(
   parameter int MAX_SYMBOLS = mtc_pkg::MAX_SYMBOLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata,
   input  mtc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mtc_pkg::rsp_type  rsp_data,
   input  mtc_pkg::cmd_type  cmd,
   output mtc_pkg::stat_type stat
);

   localparam int PAT_W = MAX_SYMBOLS;
   localparam int LEN_W = $clog2(MAX_SYMBOLS + 1);
   localparam int IDX_W = $clog2(MAX_SYMBOLS);

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_ENC_CODE,
      KIND_ENC_SPACE,
      KIND_ENC_LINE,
      KIND_DEC_CHAR,
      KIND_DEC_LINE
   } kind_type;

   logic                          mode_ff;
   logic [PAT_W-1:0]              pat_bits_ff;
   logic [PAT_W-1:0]              pat_bits_in;
   logic [LEN_W-1:0]              pat_len_ff;
   logic [LEN_W-1:0]              pat_len_in;
   logic                          pat_inv_ff;
   logic                          pat_inv_in;
   kind_type                      kind_ff;
   kind_type                      kind_in;
   mtc_pkg::code_type             enc_ff;
   mtc_pkg::enc_type              enc_hit;
   logic [7:0]                    dec_char_ff;
   logic [7:0]                    dec_char_in;
   logic [mtc_pkg::STEP_W-1:0]    step_ff;
   logic                          rsp_valid_ff;
   mtc_pkg::rsp_type              rsp_data_ff;
   logic [7:0]                    out_char;
   logic                          step_last;
   logic                          dec_clear;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_wdata;
      end
   end

   assign enc_hit = mtc_pkg::enc_find(req_data.char_in);

   always_comb begin
      kind_in = KIND_NONE;
      if (!mode_ff) begin
         if (req_data.line_end) begin
            kind_in = KIND_ENC_LINE;
         end else if (req_data.char_in == mtc_pkg::CHAR_SPACE) begin
            kind_in = KIND_ENC_SPACE;
         end else if (enc_hit.hit) begin
            kind_in = KIND_ENC_CODE;
         end
      end else begin
         if (req_data.line_end) begin
            kind_in = KIND_DEC_LINE;
         end else if (req_data.char_in == mtc_pkg::CHAR_SPACE) begin
            kind_in = KIND_DEC_CHAR;
         end
      end
   end

   // table entries are unique, so the matches can be or-ed
   always_comb begin
      logic [7:0] found;
      logic       any;
      found = '0;
      any   = 1'b0;
      for (int i = 0; i < mtc_pkg::TABLE_SIZE; i++) begin
         if (pat_len_ff == LEN_W'(mtc_pkg::TABLE_CODES[i].len) &&
             pat_bits_ff == PAT_W'(mtc_pkg::TABLE_CODES[i].bits)) begin
            found = found | mtc_pkg::TABLE_CHARS[i];
            any   = 1'b1;
         end
      end
      dec_char_in = (any && !pat_inv_ff) ? found : mtc_pkg::CHAR_QMARK;
   end

   always_comb begin
      step_last = 1'b1;
      out_char  = mtc_pkg::CHAR_SPACE;
      case (kind_ff)
         KIND_ENC_CODE: begin
            step_last = (step_ff == enc_ff.len);
            if (!step_last) begin
               out_char = enc_ff.bits[step_ff] ? mtc_pkg::CHAR_DASH : mtc_pkg::CHAR_DOT;
            end
         end
         KIND_ENC_SPACE: begin
            out_char = mtc_pkg::CHAR_SPACE;
         end
         KIND_ENC_LINE: begin
            out_char = mtc_pkg::CHAR_NL;
         end
         KIND_DEC_CHAR: begin
            out_char = dec_char_ff;
         end
         KIND_DEC_LINE: begin
            step_last = step_ff[0];
            out_char  = step_ff[0] ? mtc_pkg::CHAR_NL : dec_char_ff;
         end
         default: begin
            out_char = mtc_pkg::CHAR_SPACE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_NONE;
      end else if (cmd.load) begin
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         enc_ff      <= enc_hit.code;
         dec_char_ff <= dec_char_in;
         step_ff     <= '0;
      end else if (cmd.emit) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   assign dec_clear = cmd.emit && step_last &&
                      (kind_ff == KIND_DEC_CHAR || kind_ff == KIND_DEC_LINE);

   always_comb begin
      pat_bits_in = pat_bits_ff;
      pat_len_in  = pat_len_ff;
      pat_inv_in  = pat_inv_ff;
      if (dec_clear) begin
         pat_bits_in = '0;
         pat_len_in  = '0;
         pat_inv_in  = 1'b0;
      end else if (cmd.load && mode_ff && !req_data.line_end &&
                   req_data.char_in != mtc_pkg::CHAR_SPACE) begin
         if (req_data.char_in == mtc_pkg::CHAR_DOT ||
             req_data.char_in == mtc_pkg::CHAR_DASH) begin
            if (pat_len_ff >= LEN_W'(MAX_SYMBOLS)) begin
               pat_inv_in = 1'b1;
            end else begin
               if (req_data.char_in == mtc_pkg::CHAR_DASH) begin
                  pat_bits_in[pat_len_ff[IDX_W-1:0]] = 1'b1;
               end
               pat_len_in = pat_len_ff + 1'b1;
            end
         end else begin
            pat_inv_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bits_ff <= '0;
         pat_len_ff  <= '0;
         pat_inv_ff  <= 1'b0;
      end else begin
         pat_bits_ff <= pat_bits_in;
         pat_len_ff  <= pat_len_in;
         pat_inv_ff  <= pat_inv_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.char_out <= out_char;
         rsp_data_ff.last     <= step_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign stat.has_results = (kind_in != KIND_NONE);
   assign stat.step_last   = step_last;
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   `MTC_ASSERT_ALWAYS(a_len_bound, pat_len_ff <= LEN_W'(MAX_SYMBOLS), "pattern length overrun")
   `MTC_ASSERT_SAME(a_emit_kind, cmd.emit, kind_ff != KIND_NONE, "emit without pending word")
   `MTC_ASSERT_SAME(a_enc_step, cmd.emit && kind_ff == KIND_ENC_CODE, step_ff <= enc_ff.len, "encode step past code")
   `MTC_ASSERT_NEXT(a_dec_clear, dec_clear, pat_len_ff == '0 && !pat_inv_ff, "pattern not cleared")

endmodule

/* rtl/core/morse_text_codec.sv */
// Morse text codec: ASCII text to Morse symbols and back.
// csr channel: one bit, decode_mode (0 encode, 1 decode); always ready, write only
//   while the block is idle. Reset selects encode and clears the symbol pattern.
// req channel: one word per character (char_in) or a line end mark (line_end).
// rsp channel: output bytes, with last set on the final byte caused by a request.
// Encode: a table character gives its dots and dashes then a space, a blank one
//   space, a line end a newline, anything else nothing.
// Decode: dots and dashes are collected; a blank emits the decoded character,
//   a line end emits it followed by a newline; no match decodes to '?'.
// Sequence: a request is accepted, then each of its response words is emitted through
//   the single output register; a request makes at most seven words.
//   Requests that make no words leave the controller idle.
// req_ready is high while the controller is idle; the last word may still sit in
//   the output register while the next request is accepted.
// A stalled receiver holds the output register and the controller waits, without
//   losing or repeating words.
module morse_text_codec #(
   parameter int MAX_SYMBOLS = mtc_pkg::MAX_SYMBOLS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata,
   input  logic             req_valid,
   output logic             req_ready,
   input  mtc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mtc_pkg::rsp_type rsp_data
);

   mtc_pkg::cmd_type  cmd;
   mtc_pkg::stat_type stat;

   mtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mtc_dpath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
